FILE: src/deq_pkg.sv
// Shared widths, codes and cell commands for the double-ended queue.
`default_nettype none
package deq_pkg;
	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OPCODE_W  = 3;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LIST       = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast along the cell row
	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_SHR  = 3'd1,
		CELL_SHL  = 3'd2,
		CELL_PUT  = 3'd3,
		CELL_ROT  = 3'd4
	} cell_op_t;
endpackage
`default_nettype wire

FILE: src/deq_req_if.sv
// Request channel: opcode and value with valid/ready.
`default_nettype none
interface deq_req_if import deq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OPCODE_W-1:0]        opcode;
	logic signed [DATA_W-1:0]   value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

FILE: src/deq_rsp_if.sv
// Result channel: data, status, occupancy and last with valid/ready.
`default_nettype none
interface deq_rsp_if import deq_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [DATA_W-1:0]   data;
	logic [STATUS_W-1:0]        status;
	logic [OCC_W-1:0]           occupancy;
	logic                       last;

	modport source (output valid, output data, output status, output occupancy,
		output last, input ready);
	modport sink   (input valid, input data, input status, input occupancy,
		input last, output ready);
endinterface
`default_nettype wire

FILE: src/double_ended_queue.sv
// Top level: control, result register and the row of storage cells.
// Usage:
//   req carries one request per valid/ready handshake: an opcode (push back,
//   push front, pop front, pop back, list) and a signed 32-bit value.
//   rsp returns results; every request yields one result except a list of a
//   non-empty queue, which yields one result per stored element, front first,
//   with last set on the final one.
//   Elements sit in a row of DEPTH cells, front in cell 0. Push front and pop
//   front shift the whole row by one cell; push back and pop back touch the
//   cell at the back. A list rotates the live cells one step per result.
//   Latency: a push or pop result is valid the cycle after the request is
//   taken. A list request itself yields no result; the elements follow it.
//   Throughput: one push or pop per cycle while rsp is taken every cycle;
//   a list blocks new requests until its final element has been loaded.
//   Reset (arst_n low) empties the queue and drops any pending result.
//   When rsp.ready is low while a result is pending, the result register holds,
//   req.ready falls and a list pauses without losing its place.
`default_nettype none
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	deq_req_if.sink  req,
	deq_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d, count_m1;
	logic [CNT_W-1:0]         list_idx_q, list_idx_d;
	cell_op_t                 cell_op;
	logic                     slot_free, req_fire, full, empty;
	logic                     load;
	logic signed [DATA_W-1:0] o_data, back_data;
	status_t                  o_status;
	logic                     o_last;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_data_q;
	logic [STATUS_W-1:0]      rsp_status_q;
	logic [OCC_W-1:0]         rsp_occ_q;
	logic                     rsp_last_q;

	logic signed [DATA_W-1:0] cell_data  [DEPTH];
	logic signed [DATA_W-1:0] left_data  [DEPTH];
	logic signed [DATA_W-1:0] right_data [DEPTH];

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign req_fire  = req.valid && req.ready;
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign count_m1  = count_q - 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_data[i] = req.value;
		end else begin : g_mid
			assign left_data[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_data[i] = cell_data[i];
		end else begin : g_inner
			assign right_data[i] = cell_data[i+1];
		end
		deq_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.count      (count_q),
			.value      (req.value),
			.left_data  (left_data[i]),
			.right_data (right_data[i]),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (CNT_W'(i) == count_m1) back_data = back_data | cell_data[i];
		end
	end

	always_comb begin
		cell_op    = CELL_HOLD;
		count_d    = count_q;
		state_d    = state_q;
		list_idx_d = list_idx_q;
		load       = 1'b0;
		o_data     = '0;
		o_status   = STAT_OK;
		o_last     = 1'b1;
		if (req_fire) begin
			load = 1'b1;
			case (req.opcode)
				OP_PUSH_BACK: begin
					if (full) o_status = STAT_FULL;
					else begin
						cell_op = CELL_PUT;
						count_d = count_q + 1'b1;
					end
				end
				OP_PUSH_FRONT: begin
					if (full) o_status = STAT_FULL;
					else begin
						cell_op = CELL_SHR;
						count_d = count_q + 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (empty) o_status = STAT_EMPTY;
					else begin
						cell_op = CELL_SHL;
						o_data  = cell_data[0];
						count_d = count_m1;
					end
				end
				OP_POP_BACK: begin
					if (empty) o_status = STAT_EMPTY;
					else begin
						o_data  = back_data;
						count_d = count_m1;
					end
				end
				OP_LIST: begin
					if (empty) o_status = STAT_EMPTY;
					else begin
						load       = 1'b0;
						state_d    = S_LIST;
						list_idx_d = '0;
					end
				end
				default: o_status = STAT_OK;
			endcase
		end else if (state_q == S_LIST && slot_free) begin
			load       = 1'b1;
			cell_op    = CELL_ROT;
			o_data     = cell_data[0];
			o_last     = list_idx_q == count_m1;
			list_idx_d = list_idx_q + 1'b1;
			if (o_last) state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			list_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			list_idx_q <= list_idx_d;
			if (load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_data_q   <= o_data;
			rsp_status_q <= o_status;
			rsp_occ_q    <= OCC_W'(count_d);
			rsp_last_q   <= o_last;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data      = rsp_data_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = rsp_occ_q;
	assign rsp.last      = rsp_last_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_list_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> !req.ready)
		else $error("request taken during list");

	a_list_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> list_idx_q < count_q)
		else $error("list index past back element");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_FULL |-> rsp.occupancy == OCC_W'(DEPTH))
		else $error("full status with queue not full");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STAT_EMPTY |-> rsp.occupancy == '0 && rsp.data == '0)
		else $error("empty status with stale data or occupancy");
`endif
endmodule
`default_nettype wire

FILE: src/deq_cell.sv
// One storage cell of the queue row; position IDX counted from the front.
`default_nettype none
module deq_cell import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire cell_op_t                 op,
	input  wire logic [CNT_W-1:0]         count,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic signed [DATA_W-1:0] left_data,
	input  wire logic signed [DATA_W-1:0] right_data,
	input  wire logic signed [DATA_W-1:0] head_data,
	output logic signed [DATA_W-1:0]      data
);
	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]         back_idx;

	assign back_idx = count - 1'b1;
	assign data     = data_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_SHR: data_q <= left_data;
			CELL_SHL: data_q <= right_data;
			CELL_PUT: begin
				if (MY_IDX == count) data_q <= value;
			end
			CELL_ROT: begin
				if (MY_IDX == back_idx) data_q <= head_data;
				else if (MY_IDX < back_idx) data_q <= right_data;
			end
			default: data_q <= data_q;
		endcase
	end
endmodule
`default_nettype wire
